>>> hw/rtl/vsc_pkg.sv
// shared types and constants for the voice session control block
package vsc_pkg;

  localparam int unsigned CMD_W     = 4;
  localparam int unsigned VER_W     = 64;
  localparam int unsigned EXT_ID_W  = 64;
  localparam int unsigned SCOPE_W   = 8;
  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned OUT_DATA_W = 280;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN_CONNECT = 4'd0,
    CMD_TRANSPORT_UP  = 4'd1,
    CMD_REFRESHED     = 4'd2,
    CMD_RESTORED      = 4'd3,
    CMD_MEM_CHANGED   = 4'd4,
    CMD_LOST          = 4'd5,
    CMD_DISCONNECT    = 4'd6,
    CMD_REQUEST       = 4'd7,
    CMD_ACCEPTED      = 4'd8,
    CMD_REJECTED      = 4'd9,
    CMD_END           = 4'd10,
    CMD_ENDED         = 4'd11,
    CMD_REVOKED       = 4'd12,
    CMD_TIMEOUT       = 4'd13,
    CMD_TX_FAIL       = 4'd14
  } cmd_t;

  typedef enum logic [2:0] {
    LINK_DISCONNECTED = 3'd0,
    LINK_CONNECTING   = 3'd1,
    LINK_RECONNECTING = 3'd2,
    LINK_REFRESHING   = 3'd3,
    LINK_RESTORING    = 3'd4,
    LINK_READY        = 3'd5
  } link_state_t;

  typedef enum logic [1:0] {
    TALK_IDLE         = 2'd0,
    TALK_REQUESTING   = 2'd1,
    TALK_TRANSMITTING = 2'd2,
    TALK_ENDING       = 2'd3
  } talk_state_t;

  typedef enum logic [3:0] {
    CAUSE_NONE            = 4'd0,
    CAUSE_REJECTED        = 4'd1,
    CAUSE_RELEASED        = 4'd2,
    CAUSE_MEM_CHANGED     = 4'd3,
    CAUSE_CONN_LOST       = 4'd4,
    CAUSE_DISCONNECTED    = 4'd5,
    CAUSE_REVOKED         = 4'd6,
    CAUSE_TIMED_OUT       = 4'd7,
    CAUSE_TRANSPORT_ERROR = 4'd8
  } cause_t;

endpackage

>>> hw/rtl/voice_session_control_fsm_unit.sv
// voice session control: link and talk state machines, one event per request
//
// channel | ports                      | request contents
// --------+----------------------------+----------------------------------
// in      | in_tvalid/tready/tdata/tuser | session event and its ids
// out     | out_tvalid/tready/tdata    | applied flag and state after event
// cfg     | cfg_wr_en/cfg_wr_data      | selected scope
//
// one request per cycle sustained while results are taken; a request passes
// through the input register, then state update and result register
// rst_n clears both state machines, the context and the scope register
// a stalled result holds the result register and then the input register;
// the input side stays ready while the result register can move
module voice_session_control_fsm_unit #(
  parameter int unsigned ID_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // event_version, event_request_id, event_tx_id
  input  logic [vsc_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd
  input  logic [vsc_pkg::CMD_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // applied, link_state, talk_state, stop_cause, link_version,
  // link_version_valid, talk_context_valid, talk_request_id, talk_tx_id,
  // talk_tx_id_valid, talk_scope, talk_version, zero pad
  output logic [vsc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [vsc_pkg::SCOPE_W-1:0]       cfg_wr_data
);

  localparam int unsigned VW = vsc_pkg::VER_W;
  localparam int unsigned OUT_USED_W = 277;

  logic                              in_valid_r;
  logic [vsc_pkg::CMD_W-1:0]         in_cmd_r;
  logic [VW-1:0]                     in_ver_r;
  logic [ID_WIDTH-1:0]               in_rid_r;
  logic [ID_WIDTH-1:0]               in_tid_r;
  logic                              advance;

  logic [vsc_pkg::SCOPE_W-1:0]       scope_sel_r;

  vsc_pkg::link_state_t              link_r, link_nxt;
  vsc_pkg::talk_state_t              talk_r, talk_nxt;
  vsc_pkg::cause_t                   cause_r, cause_nxt;
  logic [VW-1:0]                     ver_r, ver_nxt;
  logic                              ver_ok_r, ver_ok_nxt;
  logic                              ctx_ok_r, ctx_ok_nxt;
  logic [ID_WIDTH-1:0]               ctx_rid_r, ctx_rid_nxt;
  logic [ID_WIDTH-1:0]               ctx_tid_r, ctx_tid_nxt;
  logic                              ctx_tid_ok_r, ctx_tid_ok_nxt;
  logic [vsc_pkg::SCOPE_W-1:0]       ctx_scope_r, ctx_scope_nxt;
  logic [VW-1:0]                     ctx_ver_r, ctx_ver_nxt;
  logic                              applied_nxt;

  logic                              out_valid_r;
  logic [vsc_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r <= in_tuser;
      in_ver_r <= in_tdata[VW-1:0];
      in_rid_r <= in_tdata[VW +: ID_WIDTH];
      in_tid_r <= in_tdata[2*VW +: ID_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scope_sel_r <= '0;
    end else if (cfg_wr_en) begin
      scope_sel_r <= cfg_wr_data;
    end
  end

  // next state of both machines
  always_comb begin
    link_nxt       = link_r;
    talk_nxt       = talk_r;
    cause_nxt      = cause_r;
    ver_nxt        = ver_r;
    ver_ok_nxt     = ver_ok_r;
    ctx_ok_nxt     = ctx_ok_r;
    ctx_rid_nxt    = ctx_rid_r;
    ctx_tid_nxt    = ctx_tid_r;
    ctx_tid_ok_nxt = ctx_tid_ok_r;
    ctx_scope_nxt  = ctx_scope_r;
    ctx_ver_nxt    = ctx_ver_r;
    applied_nxt    = 1'b0;

    case (vsc_pkg::cmd_t'(in_cmd_r))
      vsc_pkg::CMD_BEGIN_CONNECT: begin
        if (link_r == vsc_pkg::LINK_DISCONNECTED) begin
          link_nxt    = vsc_pkg::LINK_CONNECTING;
          applied_nxt = 1'b1;
        end
      end
      vsc_pkg::CMD_TRANSPORT_UP: begin
        if (link_r == vsc_pkg::LINK_CONNECTING || link_r == vsc_pkg::LINK_RECONNECTING) begin
          ver_nxt     = '0;
          ver_ok_nxt  = 1'b0;
          link_nxt    = vsc_pkg::LINK_REFRESHING;
          applied_nxt = 1'b1;
        end
      end
      vsc_pkg::CMD_REFRESHED: begin
        if (link_r == vsc_pkg::LINK_REFRESHING && in_ver_r != '0) begin
          ver_nxt     = in_ver_r;
          ver_ok_nxt  = 1'b1;
          link_nxt    = vsc_pkg::LINK_RESTORING;
          applied_nxt = 1'b1;
        end
      end
      vsc_pkg::CMD_RESTORED: begin
        if (link_r == vsc_pkg::LINK_RESTORING && ver_ok_r && in_ver_r == ver_r) begin
          link_nxt    = vsc_pkg::LINK_READY;
          applied_nxt = 1'b1;
        end
      end
      vsc_pkg::CMD_MEM_CHANGED,
      vsc_pkg::CMD_LOST,
      vsc_pkg::CMD_DISCONNECT: begin
        if (in_cmd_r == vsc_pkg::CMD_MEM_CHANGED) begin
          if (link_r == vsc_pkg::LINK_READY && ver_ok_r && in_ver_r > ver_r) begin
            ver_nxt     = in_ver_r;
            link_nxt    = vsc_pkg::LINK_RESTORING;
            cause_nxt   = vsc_pkg::CAUSE_MEM_CHANGED;
            applied_nxt = 1'b1;
          end
        end else if (in_cmd_r == vsc_pkg::CMD_LOST) begin
          if (link_r != vsc_pkg::LINK_DISCONNECTED &&
              link_r != vsc_pkg::LINK_RECONNECTING) begin
            ver_nxt     = '0;
            ver_ok_nxt  = 1'b0;
            link_nxt    = vsc_pkg::LINK_RECONNECTING;
            cause_nxt   = vsc_pkg::CAUSE_CONN_LOST;
            applied_nxt = 1'b1;
          end
        end else begin
          if (link_r != vsc_pkg::LINK_DISCONNECTED) begin
            ver_nxt     = '0;
            ver_ok_nxt  = 1'b0;
            link_nxt    = vsc_pkg::LINK_DISCONNECTED;
            cause_nxt   = vsc_pkg::CAUSE_DISCONNECTED;
            applied_nxt = 1'b1;
          end
        end
        // link change stops any talk that is not idle
        if (applied_nxt && talk_r != vsc_pkg::TALK_IDLE) begin
          talk_nxt       = vsc_pkg::TALK_IDLE;
          ctx_ok_nxt     = 1'b0;
          ctx_rid_nxt    = '0;
          ctx_tid_nxt    = '0;
          ctx_tid_ok_nxt = 1'b0;
          ctx_scope_nxt  = '0;
          ctx_ver_nxt    = '0;
        end else begin
          cause_nxt = cause_r;
        end
      end
      vsc_pkg::CMD_REQUEST: begin
        if (link_r == vsc_pkg::LINK_READY && ver_ok_r && talk_r == vsc_pkg::TALK_IDLE &&
            ver_r != '0) begin
          ctx_ok_nxt     = 1'b1;
          ctx_rid_nxt    = in_rid_r;
          ctx_tid_nxt    = '0;
          ctx_tid_ok_nxt = 1'b0;
          ctx_scope_nxt  = scope_sel_r;
          ctx_ver_nxt    = ver_r;
          cause_nxt      = vsc_pkg::CAUSE_NONE;
          talk_nxt       = vsc_pkg::TALK_REQUESTING;
          applied_nxt    = 1'b1;
        end
      end
      vsc_pkg::CMD_ACCEPTED: begin
        if (talk_r == vsc_pkg::TALK_REQUESTING && ctx_ok_r && ctx_rid_r == in_rid_r) begin
          ctx_tid_nxt    = in_tid_r;
          ctx_tid_ok_nxt = 1'b1;
          talk_nxt       = vsc_pkg::TALK_TRANSMITTING;
          applied_nxt    = 1'b1;
        end
      end
      vsc_pkg::CMD_REJECTED,
      vsc_pkg::CMD_END,
      vsc_pkg::CMD_ENDED,
      vsc_pkg::CMD_REVOKED,
      vsc_pkg::CMD_TIMEOUT,
      vsc_pkg::CMD_TX_FAIL: begin
        if (in_cmd_r == vsc_pkg::CMD_REJECTED) begin
          if (talk_r == vsc_pkg::TALK_REQUESTING && ctx_ok_r && ctx_rid_r == in_rid_r) begin
            cause_nxt   = vsc_pkg::CAUSE_REJECTED;
            applied_nxt = 1'b1;
          end
        end else if (in_cmd_r == vsc_pkg::CMD_END) begin
          if (talk_r == vsc_pkg::TALK_REQUESTING) begin
            cause_nxt   = vsc_pkg::CAUSE_RELEASED;
            applied_nxt = 1'b1;
          end
        end else if (in_cmd_r == vsc_pkg::CMD_ENDED) begin
          if (talk_r == vsc_pkg::TALK_ENDING && ctx_ok_r && ctx_tid_ok_r &&
              ctx_tid_r == in_tid_r) begin
            cause_nxt   = vsc_pkg::CAUSE_RELEASED;
            applied_nxt = 1'b1;
          end
        end else if (talk_r != vsc_pkg::TALK_IDLE) begin
          applied_nxt = 1'b1;
          if (in_cmd_r == vsc_pkg::CMD_REVOKED) begin
            cause_nxt = vsc_pkg::CAUSE_REVOKED;
          end else if (in_cmd_r == vsc_pkg::CMD_TIMEOUT) begin
            cause_nxt = vsc_pkg::CAUSE_TIMED_OUT;
          end else begin
            cause_nxt = vsc_pkg::CAUSE_TRANSPORT_ERROR;
          end
        end
        if (applied_nxt) begin
          talk_nxt       = vsc_pkg::TALK_IDLE;
          ctx_ok_nxt     = 1'b0;
          ctx_rid_nxt    = '0;
          ctx_tid_nxt    = '0;
          ctx_tid_ok_nxt = 1'b0;
          ctx_scope_nxt  = '0;
          ctx_ver_nxt    = '0;
        end
        // end while transmitting only moves to ending
        if (in_cmd_r == vsc_pkg::CMD_END && talk_r == vsc_pkg::TALK_TRANSMITTING) begin
          talk_nxt    = vsc_pkg::TALK_ENDING;
          applied_nxt = 1'b1;
        end
      end
      default: begin
        applied_nxt = 1'b0;
      end
    endcase
  end

  // result word
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[0]       = applied_nxt;
    out_data_nxt[3:1]     = link_nxt;
    out_data_nxt[5:4]     = talk_nxt;
    out_data_nxt[9:6]     = cause_nxt;
    out_data_nxt[73:10]   = ver_nxt;
    out_data_nxt[74]      = ver_ok_nxt;
    out_data_nxt[75]      = ctx_ok_nxt;
    out_data_nxt[139:76]  = vsc_pkg::EXT_ID_W'(ctx_rid_nxt);
    out_data_nxt[203:140] = vsc_pkg::EXT_ID_W'(ctx_tid_nxt);
    out_data_nxt[204]     = ctx_tid_ok_nxt;
    out_data_nxt[212:205] = ctx_scope_nxt;
    out_data_nxt[OUT_USED_W-1:213] = ctx_ver_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r       <= vsc_pkg::LINK_DISCONNECTED;
      talk_r       <= vsc_pkg::TALK_IDLE;
      cause_r      <= vsc_pkg::CAUSE_NONE;
      ver_r        <= '0;
      ver_ok_r     <= 1'b0;
      ctx_ok_r     <= 1'b0;
      ctx_rid_r    <= '0;
      ctx_tid_r    <= '0;
      ctx_tid_ok_r <= 1'b0;
      ctx_scope_r  <= '0;
      ctx_ver_r    <= '0;
    end else if (advance) begin
      link_r       <= link_nxt;
      talk_r       <= talk_nxt;
      cause_r      <= cause_nxt;
      ver_r        <= ver_nxt;
      ver_ok_r     <= ver_ok_nxt;
      ctx_ok_r     <= ctx_ok_nxt;
      ctx_rid_r    <= ctx_rid_nxt;
      ctx_tid_r    <= ctx_tid_nxt;
      ctx_tid_ok_r <= ctx_tid_ok_nxt;
      ctx_scope_r  <= ctx_scope_nxt;
      ctx_ver_r    <= ctx_ver_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> bench/voice_session_control_fsm_unit_tb.sv
// self-checking bench for the voice session control block: event stream in, state stream out
module voice_session_control_fsm_unit_tb;

  localparam logic [3:0]  CMD_UNKNOWN = 4'hF;
  localparam logic [63:0] ALL_ONES    = '1;
  localparam logic [63:0] NIL         = '0;
  localparam int          STALL_LIMIT = 1000;
  localparam int          PHASE_ITEMS = 280;

  // one state request as packed on out_tdata, highest field first
  typedef struct packed {
    logic [2:0]           pad;
    logic [63:0]          talk_version;
    logic [7:0]           talk_scope;
    logic                 talk_tx_id_valid;
    logic [63:0]          talk_tx_id;
    logic [63:0]          talk_request_id;
    logic                 talk_context_valid;
    logic                 link_version_valid;
    logic [63:0]          link_version;
    vsc_pkg::cause_t      stop_cause;
    vsc_pkg::talk_state_t talk_state;
    vsc_pkg::link_state_t link_state;
    logic                 applied;
  } session_view_t;

  typedef struct {
    logic [3:0]           cmd;
    logic [63:0]          ver;
    logic [63:0]          rid;
    logic [63:0]          tid;
    bit                   typed;
    bit                   applied;
    vsc_pkg::link_state_t lk;
    vsc_pkg::talk_state_t tk;
    vsc_pkg::cause_t      cause;
  } directed_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  // event_version, event_request_id, event_tx_id
  logic [vsc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  // cmd
  logic [vsc_pkg::CMD_W-1:0]      in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // applied, link_state, talk_state, stop_cause, link_version, link_version_valid,
  // talk_context_valid, talk_request_id, talk_tx_id, talk_tx_id_valid, talk_scope,
  // talk_version, zero pad
  logic [vsc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_wr_en = 1'b0;
  logic [vsc_pkg::SCOPE_W-1:0]    cfg_wr_data = '0;

  voice_session_control_fsm_unit #(.ID_WIDTH(64)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // session state mirror
  vsc_pkg::link_state_t lk = vsc_pkg::LINK_DISCONNECTED;
  vsc_pkg::talk_state_t tk = vsc_pkg::TALK_IDLE;
  vsc_pkg::cause_t      last_stop = vsc_pkg::CAUSE_NONE;
  logic [63:0]          mver = '0;
  logic                 mver_ok = 1'b0;
  logic                 ctx_ok = 1'b0;
  logic [63:0]          ctx_rid = '0;
  logic [63:0]          ctx_tid = '0;
  logic                 ctx_tid_ok = 1'b0;
  logic [7:0]           ctx_scope = '0;
  logic [63:0]          ctx_ver = '0;
  logic [7:0]           scope_reg = '0;

  session_view_t pending_states[$];
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            quiet_cycles = 0;

  function automatic void drop_talk(vsc_pkg::cause_t why);
    ctx_ok = 1'b0;
    ctx_rid = '0;
    ctx_tid = '0;
    ctx_tid_ok = 1'b0;
    ctx_scope = '0;
    ctx_ver = '0;
    last_stop = why;
    tk = vsc_pkg::TALK_IDLE;
  endfunction

  function automatic bit halt_talk(vsc_pkg::cause_t why);
    if (tk == vsc_pkg::TALK_IDLE) return 1'b0;
    drop_talk(why);
    return 1'b1;
  endfunction

  function automatic session_view_t session_next(logic [3:0] c, logic [63:0] v,
                                                 logic [63:0] rid, logic [63:0] tid);
    session_view_t s;
    bit ok;
    ok = 1'b0;
    case (c)
      vsc_pkg::CMD_BEGIN_CONNECT: if (lk == vsc_pkg::LINK_DISCONNECTED) begin
        lk = vsc_pkg::LINK_CONNECTING;
        ok = 1'b1;
      end
      vsc_pkg::CMD_TRANSPORT_UP:
        if (lk == vsc_pkg::LINK_CONNECTING || lk == vsc_pkg::LINK_RECONNECTING) begin
          mver = '0;
          mver_ok = 1'b0;
          lk = vsc_pkg::LINK_REFRESHING;
          ok = 1'b1;
        end
      vsc_pkg::CMD_REFRESHED: if (lk == vsc_pkg::LINK_REFRESHING && v != 0) begin
        mver = v;
        mver_ok = 1'b1;
        lk = vsc_pkg::LINK_RESTORING;
        ok = 1'b1;
      end
      vsc_pkg::CMD_RESTORED: if (lk == vsc_pkg::LINK_RESTORING && mver_ok && v == mver) begin
        lk = vsc_pkg::LINK_READY;
        ok = 1'b1;
      end
      vsc_pkg::CMD_MEM_CHANGED: if (lk == vsc_pkg::LINK_READY && mver_ok && v > mver) begin
        mver = v;
        lk = vsc_pkg::LINK_RESTORING;
        void'(halt_talk(vsc_pkg::CAUSE_MEM_CHANGED));
        ok = 1'b1;
      end
      vsc_pkg::CMD_LOST:
        if (lk != vsc_pkg::LINK_DISCONNECTED && lk != vsc_pkg::LINK_RECONNECTING) begin
          mver = '0;
          mver_ok = 1'b0;
          lk = vsc_pkg::LINK_RECONNECTING;
          void'(halt_talk(vsc_pkg::CAUSE_CONN_LOST));
          ok = 1'b1;
        end
      vsc_pkg::CMD_DISCONNECT: if (lk != vsc_pkg::LINK_DISCONNECTED) begin
        mver = '0;
        mver_ok = 1'b0;
        lk = vsc_pkg::LINK_DISCONNECTED;
        void'(halt_talk(vsc_pkg::CAUSE_DISCONNECTED));
        ok = 1'b1;
      end
      vsc_pkg::CMD_REQUEST:
        if (lk == vsc_pkg::LINK_READY && mver_ok && tk == vsc_pkg::TALK_IDLE &&
            mver != 0) begin
          ctx_ok = 1'b1;
          ctx_rid = rid;
          ctx_tid = '0;
          ctx_tid_ok = 1'b0;
          ctx_scope = scope_reg;
          ctx_ver = mver;
          last_stop = vsc_pkg::CAUSE_NONE;
          tk = vsc_pkg::TALK_REQUESTING;
          ok = 1'b1;
        end
      vsc_pkg::CMD_ACCEPTED:
        if (tk == vsc_pkg::TALK_REQUESTING && ctx_ok && ctx_rid == rid) begin
          ctx_tid = tid;
          ctx_tid_ok = 1'b1;
          tk = vsc_pkg::TALK_TRANSMITTING;
          ok = 1'b1;
        end
      vsc_pkg::CMD_REJECTED:
        if (tk == vsc_pkg::TALK_REQUESTING && ctx_ok && ctx_rid == rid) begin
          drop_talk(vsc_pkg::CAUSE_REJECTED);
          ok = 1'b1;
        end
      vsc_pkg::CMD_END: begin
        if (tk == vsc_pkg::TALK_REQUESTING) begin
          drop_talk(vsc_pkg::CAUSE_RELEASED);
          ok = 1'b1;
        end else if (tk == vsc_pkg::TALK_TRANSMITTING) begin
          tk = vsc_pkg::TALK_ENDING;
          ok = 1'b1;
        end
      end
      vsc_pkg::CMD_ENDED:
        if (tk == vsc_pkg::TALK_ENDING && ctx_ok && ctx_tid_ok && ctx_tid == tid) begin
          drop_talk(vsc_pkg::CAUSE_RELEASED);
          ok = 1'b1;
        end
      vsc_pkg::CMD_REVOKED: ok = halt_talk(vsc_pkg::CAUSE_REVOKED);
      vsc_pkg::CMD_TIMEOUT: ok = halt_talk(vsc_pkg::CAUSE_TIMED_OUT);
      vsc_pkg::CMD_TX_FAIL: ok = halt_talk(vsc_pkg::CAUSE_TRANSPORT_ERROR);
      default: ;
    endcase
    s = '0;
    s.applied = ok;
    s.link_state = lk;
    s.talk_state = tk;
    s.stop_cause = last_stop;
    s.link_version = mver_ok ? mver : '0;
    s.link_version_valid = mver_ok;
    s.talk_context_valid = ctx_ok;
    s.talk_request_id = ctx_ok ? ctx_rid : '0;
    s.talk_tx_id = (ctx_ok && ctx_tid_ok) ? ctx_tid : '0;
    s.talk_tx_id_valid = ctx_ok && ctx_tid_ok;
    s.talk_scope = ctx_ok ? ctx_scope : '0;
    s.talk_version = ctx_ok ? ctx_ver : '0;
    return s;
  endfunction

  task automatic flag_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_state(session_view_t want, session_view_t got);
    flag_field("applied", want.applied, got.applied);
    flag_field("link_state", want.link_state, got.link_state);
    flag_field("talk_state", want.talk_state, got.talk_state);
    flag_field("stop_cause", want.stop_cause, got.stop_cause);
    flag_field("link_version", want.link_version, got.link_version);
    flag_field("link_version_valid", want.link_version_valid, got.link_version_valid);
    flag_field("talk_context_valid", want.talk_context_valid, got.talk_context_valid);
    flag_field("talk_request_id", want.talk_request_id, got.talk_request_id);
    flag_field("talk_tx_id", want.talk_tx_id, got.talk_tx_id);
    flag_field("talk_tx_id_valid", want.talk_tx_id_valid, got.talk_tx_id_valid);
    flag_field("talk_scope", want.talk_scope, got.talk_scope);
    flag_field("talk_version", want.talk_version, got.talk_version);
    flag_field("pad", want.pad, got.pad);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly requests that move the session forward, some noise and broken ids
  task automatic choose_event(output logic [3:0] c, output logic [63:0] v,
                              output logic [63:0] rid, output logic [63:0] tid);
    int roll;
    roll = $urandom_range(99);
    v = rand_word();
    rid = rand_word();
    tid = rand_word();
    c = 4'($urandom_range(15));
    if (roll >= 15) begin
      case (lk)
        vsc_pkg::LINK_DISCONNECTED: c = vsc_pkg::CMD_BEGIN_CONNECT;
        vsc_pkg::LINK_CONNECTING, vsc_pkg::LINK_RECONNECTING:
          c = (roll < 20) ? vsc_pkg::CMD_LOST : vsc_pkg::CMD_TRANSPORT_UP;
        vsc_pkg::LINK_REFRESHING: begin
          c = vsc_pkg::CMD_REFRESHED;
          if (roll < 90) v = 64'($urandom_range(1, 5000));
        end
        vsc_pkg::LINK_RESTORING: begin
          c = vsc_pkg::CMD_RESTORED;
          if (roll < 95) v = mver;
        end
        default: begin
          roll = $urandom_range(99);
          if (roll < 4) begin
            c = vsc_pkg::CMD_MEM_CHANGED;
            if (roll < 3) v = mver + 64'($urandom_range(1, 100));
          end else if (roll < 6) begin
            c = vsc_pkg::CMD_LOST;
          end else if (roll < 8) begin
            c = vsc_pkg::CMD_DISCONNECT;
          end else begin
            roll = $urandom_range(99);
            case (tk)
              vsc_pkg::TALK_IDLE: c = vsc_pkg::CMD_REQUEST;
              vsc_pkg::TALK_REQUESTING: begin
                if (roll < 60) begin
                  c = vsc_pkg::CMD_ACCEPTED;
                  rid = ctx_rid;
                end else if (roll < 75) begin
                  c = vsc_pkg::CMD_REJECTED;
                  rid = ctx_rid;
                end else if (roll < 85) c = vsc_pkg::CMD_END;
                else if (roll < 90) c = vsc_pkg::CMD_TIMEOUT;
                else if (roll < 95) c = vsc_pkg::CMD_ACCEPTED;
                else c = vsc_pkg::CMD_REVOKED;
              end
              vsc_pkg::TALK_TRANSMITTING: begin
                if (roll < 70) c = vsc_pkg::CMD_END;
                else if (roll < 80) c = vsc_pkg::CMD_REVOKED;
                else if (roll < 90) c = vsc_pkg::CMD_TIMEOUT;
                else c = vsc_pkg::CMD_TX_FAIL;
              end
              default: begin
                c = (roll < 92) ? vsc_pkg::CMD_ENDED : vsc_pkg::CMD_TX_FAIL;
                if (roll < 85) tid = ctx_tid;
              end
            endcase
          end
        end
      endcase
    end
  endtask

  task automatic send_event(logic [3:0] c, logic [63:0] v, logic [63:0] rid,
                            logic [63:0] tid, output session_view_t predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {tid, rid, v};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predicted = session_next(c, v, rid, tid);
    pending_states.push_back(predicted);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_states.size() != 0);
  endtask

  task automatic write_scope(logic [7:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scope_reg = value;
  endtask

  always @(posedge clk) begin
    if (out_tvalid === 1'b1 && out_tready) begin
      if (pending_states.size() == 0) begin
        $error("result with no pending request");
        mismatches++;
      end else begin
        compare_state(pending_states.pop_front(), session_view_t'(out_tdata));
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    directed_row_t directed_rows[25];
    logic [3:0]    c;
    logic [63:0]   v;
    logic [63:0]   rid;
    logic [63:0]   tid;
    session_view_t view;

    directed_rows = '{
      '{CMD_UNKNOWN, ALL_ONES, ALL_ONES, ALL_ONES, 1, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_REQUEST, NIL, NIL, NIL, 1, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_TRANSPORT_UP, NIL, NIL, NIL, 1, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_BEGIN_CONNECT, NIL, NIL, NIL, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_TRANSPORT_UP, NIL, NIL, NIL, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_REFRESHED, NIL, NIL, NIL, 1, 0,
        vsc_pkg::LINK_REFRESHING, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_REFRESHED, ALL_ONES, NIL, NIL, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_RESTORED, 64'd1, NIL, NIL, 1, 0,
        vsc_pkg::LINK_RESTORING, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_RESTORED, ALL_ONES, NIL, NIL, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_REQUEST, NIL, ALL_ONES, NIL, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_ACCEPTED, NIL, NIL, ALL_ONES, 1, 0,
        vsc_pkg::LINK_READY, vsc_pkg::TALK_REQUESTING, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_ACCEPTED, NIL, ALL_ONES, ALL_ONES, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_ENDED, NIL, NIL, ALL_ONES, 1, 0,
        vsc_pkg::LINK_READY, vsc_pkg::TALK_TRANSMITTING, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_END, NIL, NIL, NIL, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_ENDED, NIL, NIL, ALL_ONES, 1, 1,
        vsc_pkg::LINK_READY, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_RELEASED},
      '{vsc_pkg::CMD_MEM_CHANGED, ALL_ONES, NIL, NIL, 1, 0,
        vsc_pkg::LINK_READY, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_RELEASED},
      '{vsc_pkg::CMD_REQUEST, NIL, NIL, NIL, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_REJECTED, NIL, NIL, NIL, 1, 1,
        vsc_pkg::LINK_READY, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_REJECTED},
      '{vsc_pkg::CMD_REQUEST, NIL, ALL_ONES, NIL, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_TIMEOUT, NIL, NIL, NIL, 1, 1,
        vsc_pkg::LINK_READY, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_TIMED_OUT},
      '{vsc_pkg::CMD_REQUEST, NIL, 64'h5, NIL, 0, 0,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_NONE},
      '{vsc_pkg::CMD_TX_FAIL, NIL, NIL, NIL, 1, 1,
        vsc_pkg::LINK_READY, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_TRANSPORT_ERROR},
      '{vsc_pkg::CMD_REVOKED, NIL, NIL, NIL, 1, 0,
        vsc_pkg::LINK_READY, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_TRANSPORT_ERROR},
      '{vsc_pkg::CMD_LOST, NIL, NIL, NIL, 1, 1,
        vsc_pkg::LINK_RECONNECTING, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_TRANSPORT_ERROR},
      '{vsc_pkg::CMD_DISCONNECT, NIL, NIL, NIL, 1, 1,
        vsc_pkg::LINK_DISCONNECTED, vsc_pkg::TALK_IDLE, vsc_pkg::CAUSE_TRANSPORT_ERROR}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 49;
    write_scope(8'hFF);
    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].cmd, directed_rows[i].ver, directed_rows[i].rid,
                 directed_rows[i].tid, view);
      if (directed_rows[i].typed) begin
        flag_field("applied", directed_rows[i].applied, view.applied);
        flag_field("link_state", directed_rows[i].lk, view.link_state);
        flag_field("talk_state", directed_rows[i].tk, view.talk_state);
        flag_field("stop_cause", directed_rows[i].cause, view.stop_cause);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 49;
          write_scope(8'($urandom_range(1, 254)));
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 25;
          write_scope(8'h00);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_scope(8'($urandom_range(255)));
        end
      endcase
      repeat (PHASE_ITEMS) begin
        choose_event(c, v, rid, tid);
        send_event(c, v, rid, tid, view);
        // hold off until the pipe is empty now and then
        if ($urandom_range(99) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
